[hdl/tdwq_pkg.sv]
// Shared types and constants for the tick delay wakeup queue.
// No dependencies; every other file in hdl/ uses this package.
package tdwq_pkg;

   localparam int TASK_COUNT = 32;
   localparam int TICK_W     = 31;
   localparam int TID_W      = 5;
   localparam int KIND_W     = 2;
   localparam int CNT_W      = $clog2(TASK_COUNT + 1);

   localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

   typedef enum logic [KIND_W-1:0] {
      KIND_TICK  = 2'd0,
      KIND_QUERY = 2'd1,
      KIND_DELAY = 2'd2,
      KIND_UNTIL = 2'd3
   } kind_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic tick;    // advance time, reply to the notifier
      logic reply;   // reply to the requester with the current time, last
      logic insert;  // queue the requester at its deadline
      logic pop;     // reply to the head waiter and drop it
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic due;     // request deadline already reached
      logic full;    // waiter list holds TASK_COUNT entries
      logic last;    // pending response closes its request
   } status_type;

endpackage

[hdl/tdwq_ctrl.sv]
// Controller for the tick delay wakeup queue: request decode and response sequencing.
// Depends on tdwq_pkg.
module tdwq_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  tdwq_pkg::kind_type       req_kind,
   input  logic                     rsp_ready,
   input  tdwq_pkg::status_type     status,
   output logic                     req_ready,
   output logic                     rsp_valid,
   output tdwq_pkg::cmd_type        cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               case (req_kind)
                  tdwq_pkg::KIND_TICK: begin
                     cmd.tick = 1'b1;
                     state_in = ST_RESP;
                  end
                  tdwq_pkg::KIND_QUERY: begin
                     cmd.reply = 1'b1;
                     state_in  = ST_RESP;
                  end
                  default: begin
                     if (status.due) begin
                        cmd.reply = 1'b1;
                        state_in  = ST_RESP;
                     end else if (!status.full) begin
                        cmd.insert = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_RESP: begin
            // advance to the next due waiter, or close the request
            if (rsp_ready) begin
               if (status.last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.pop = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

[hdl/tdwq_dpath.sv]
// Datapath for the tick delay wakeup queue: time counter, sorted waiter list, response register.
// Depends on tdwq_pkg.
module tdwq_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  tdwq_pkg::kind_type              req_kind,
   input  logic [tdwq_pkg::TID_W-1:0]      req_tid,
   input  logic [tdwq_pkg::TICK_W-1:0]     req_ticks,
   input  tdwq_pkg::cmd_type               cmd,
   output tdwq_pkg::status_type            status,
   output logic [tdwq_pkg::TID_W-1:0]      rsp_reply_tid,
   output logic [tdwq_pkg::TICK_W-1:0]     rsp_reply_time,
   output logic                            rsp_last
);

   localparam int N = tdwq_pkg::TASK_COUNT;

   logic [tdwq_pkg::TICK_W-1:0] now_ff;
   logic [tdwq_pkg::CNT_W-1:0]  count_ff;
   logic [tdwq_pkg::TICK_W-1:0] wake_ff [N];
   logic [tdwq_pkg::TID_W-1:0]  id_ff   [N];
   logic [tdwq_pkg::TID_W-1:0]  tid_ff;
   logic [tdwq_pkg::TICK_W-1:0] time_ff;
   logic                        last_ff;

   logic [tdwq_pkg::TICK_W:0]   sum;
   logic [tdwq_pkg::TICK_W-1:0] deadline;
   logic [tdwq_pkg::TICK_W-1:0] now_in;
   logic                        tick_last;
   logic                        pop_last;
   logic [N-1:0]                le;

   // saturating deadline
   always_comb begin
      sum = {1'b0, now_ff} + {1'b0, req_ticks};
      if (req_kind == tdwq_pkg::KIND_DELAY) begin
         deadline = sum[tdwq_pkg::TICK_W] ? tdwq_pkg::TICK_MAX : sum[tdwq_pkg::TICK_W-1:0];
      end else begin
         deadline = req_ticks;
      end
      now_in    = (now_ff == tdwq_pkg::TICK_MAX) ? now_ff : now_ff + tdwq_pkg::TICK_W'(1);
      tick_last = !((count_ff != '0) && (wake_ff[0] <= now_in));
      pop_last  = !((count_ff > tdwq_pkg::CNT_W'(1)) && (wake_ff[1] <= now_ff));
   end

   // entries at or before the new deadline stay put; the list is sorted, so le is a thermometer
   for (genvar i = 0; i < N; i++) begin : g_cmp
      assign le[i] = (tdwq_pkg::CNT_W'(i) < count_ff) && (wake_ff[i] <= deadline);
   end

   for (genvar i = 0; i < N; i++) begin : g_entry
      always_ff @(posedge clock) begin
         if (cmd.insert && !le[i]) begin
            if (i == 0) begin
               wake_ff[i] <= deadline;
               id_ff[i]   <= req_tid;
            end else if (le[(i == 0) ? 0 : i-1]) begin
               wake_ff[i] <= deadline;
               id_ff[i]   <= req_tid;
            end else begin
               wake_ff[i] <= wake_ff[(i == 0) ? 0 : i-1];
               id_ff[i]   <= id_ff[(i == 0) ? 0 : i-1];
            end
         end else if (cmd.pop && (i < N-1)) begin
            wake_ff[i] <= wake_ff[(i < N-1) ? i+1 : i];
            id_ff[i]   <= id_ff[(i < N-1) ? i+1 : i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (cmd.tick) begin
            now_ff <= now_in;
         end
         if (cmd.insert) begin
            count_ff <= count_ff + tdwq_pkg::CNT_W'(1);
         end else if (cmd.pop) begin
            count_ff <= count_ff - tdwq_pkg::CNT_W'(1);
         end
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.tick) begin
         tid_ff  <= req_tid;
         time_ff <= now_in;
         last_ff <= tick_last;
      end else if (cmd.reply) begin
         tid_ff  <= req_tid;
         time_ff <= now_ff;
         last_ff <= 1'b1;
      end else if (cmd.pop) begin
         tid_ff  <= id_ff[0];
         time_ff <= now_ff;
         last_ff <= pop_last;
      end
   end

   assign status.due  = (deadline <= now_ff);
   assign status.full = (count_ff == tdwq_pkg::CNT_W'(N));
   assign status.last = last_ff;

   assign rsp_reply_tid  = tid_ff;
   assign rsp_reply_time = time_ff;
   assign rsp_last       = last_ff;

endmodule

[hdl/tick_delay_wakeup_queue.sv]
// Top level of the tick delay wakeup queue.
// Depends on tdwq_pkg, tdwq_ctrl and tdwq_dpath.
//
// The block keeps a saturating tick count and up to TASK_COUNT waiting tasks sorted by
// wake deadline (equal deadlines in arrival order). Requests that answer show their
// first response in the cycle after they are taken in. A tick answers the notifier and
// then every waiter whose deadline has been reached, one response per cycle while
// rsp_ready is high. Queries and due delays answer once; a delay that is queued gives no
// response. The response register sets the pace: a new request is taken only once the
// last response of the previous one has been taken. Insertion and removal act on all
// list entries in parallel, so neither depends on the list length. A delay that would be
// queued on a full list is dropped with no response.
module tick_delay_wakeup_queue (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [tdwq_pkg::KIND_W-1:0]     req_kind,
   input  logic [tdwq_pkg::TID_W-1:0]      req_tid,
   input  logic [tdwq_pkg::TICK_W-1:0]     req_ticks,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [tdwq_pkg::TID_W-1:0]      rsp_reply_tid,
   output logic [tdwq_pkg::TICK_W-1:0]     rsp_reply_time,
   output logic                            rsp_last
);

   tdwq_pkg::cmd_type    cmd;
   tdwq_pkg::status_type status;
   tdwq_pkg::kind_type   kind;

   assign kind = tdwq_pkg::kind_type'(req_kind);

   // decode requests, sequence responses
   tdwq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (kind),
      .rsp_ready (rsp_ready),
      .status    (status),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // hold time, waiter list and the pending response
   tdwq_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_kind       (kind),
      .req_tid        (req_tid),
      .req_ticks      (req_ticks),
      .cmd            (cmd),
      .status         (status),
      .rsp_reply_tid  (rsp_reply_tid),
      .rsp_reply_time (rsp_reply_time),
      .rsp_last       (rsp_last)
   );

endmodule

[hdl/tdwq_checker.sv]
// Port-level checks for the tick delay wakeup queue, bound to the top level.
// Depends on tdwq_pkg and tick_delay_wakeup_queue.
module tdwq_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic [tdwq_pkg::KIND_W-1:0]     req_kind,
   input logic [tdwq_pkg::TID_W-1:0]      req_tid,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [tdwq_pkg::TID_W-1:0]      rsp_reply_tid,
   input logic                            rsp_last
);

   // hold a response until it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before it was taken");

   // never take a request while responses are pending
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken while a response is pending");

   // a response that is not last is followed at once by another
   a_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("response chain broken before last");

   // a query answers its sender alone
   a_query: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == tdwq_pkg::KIND_QUERY)
      |=> rsp_valid && rsp_last && (rsp_reply_tid == $past(req_tid)))
      else $error("query not answered to its sender");

   // a tick answers the notifier first
   a_tick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_kind == tdwq_pkg::KIND_TICK)
      |=> rsp_valid && (rsp_reply_tid == $past(req_tid)))
      else $error("tick not answered to its notifier");

endmodule

bind tick_delay_wakeup_queue tdwq_checker u_tdwq_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .req_kind      (req_kind),
   .req_tid       (req_tid),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_reply_tid (rsp_reply_tid),
   .rsp_last      (rsp_last)
);
